FILE: rtl/rbd_pkg.sv
// shared types and constants of the ring buffer deque
package rbd_pkg;

   // default ring depth
   localparam int RBD_DEPTH = 256;

   // command codes
   localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
   localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
   localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
   localparam logic [1:0] CMD_POP_BACK   = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // field widths fixed by the item layout
   localparam int VALUE_W   = 32;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int REQ_TDATA_W = ((CMD_W + VALUE_W + 7) / 8) * 8;

   // controller to datapath
   typedef struct packed {
      logic take;      // item transfer this cycle
      logic push;      // command is a push
      logic at_front;  // command works on the front end
   } rbd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
   } rbd_stat_type;

endpackage

FILE: rtl/rbd_ctrl.sv
// controller state machine of the ring buffer deque
module rbd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [1:0]          req_cmd,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  rbd_pkg::rbd_stat_type stat,
   output rbd_pkg::rbd_cmd_type  cmd
);
   import rbd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_HOLD = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       take;
   logic       is_push;
   logic       pop_ok;

   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_HOLD) && rsp_tready);
   assign rsp_tvalid = (state_ff == S_HOLD);
   assign take       = req_tvalid && req_tready;
   assign is_push    = (req_cmd == CMD_PUSH_FRONT) || (req_cmd == CMD_PUSH_BACK);
   assign pop_ok     = !is_push && !stat.empty;

   assign cmd.take     = take;
   assign cmd.push     = is_push;
   assign cmd.at_front = (req_cmd == CMD_PUSH_FRONT) || (req_cmd == CMD_POP_FRONT);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               state_in = pop_ok ? S_READ : S_HOLD;
            end
         end
         S_READ: begin
            state_in = S_HOLD;
         end
         S_HOLD: begin
            if (take) begin
               state_in = pop_ok ? S_READ : S_HOLD;
            end else if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/rbd_datapath.sv
// pointers, occupancy, ring memory and result registers of the deque
module rbd_datapath #(
   parameter int RING_DEPTH = rbd_pkg::RBD_DEPTH,
   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
   localparam int CNT_W = $clog2(RING_DEPTH + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  rbd_pkg::rbd_cmd_type         cmd,
   input  logic [rbd_pkg::VALUE_W-1:0]  push_value,
   output rbd_pkg::rbd_stat_type        stat,
   output logic [rbd_pkg::VALUE_W-1:0]  pop_value,
   output logic [rbd_pkg::STATUS_W-1:0] status,
   output logic [CNT_W-1:0]             item_count,
   output logic [PTR_W:0]               front_slot,
   output logic [PTR_W:0]               rear_slot
);
   import rbd_pkg::*;

   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(RING_DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

   logic [VALUE_W-1:0]  ring_mem [RING_DEPTH];
   logic [VALUE_W-1:0]  rd_data_ff;
   logic [PTR_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [PTR_W-1:0]    wr_addr, rd_addr;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                pop_sel_ff;
   logic                wr_en, rd_en;

   function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p);
      return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
      return (p == '0) ? LAST_SLOT : p - PTR_W'(1);
   endfunction

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == FULL_CNT);

   assign wr_en = cmd.take && cmd.push && !stat.full;
   assign rd_en = cmd.take && !cmd.push && !stat.empty;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      wr_addr   = head_ff;
      rd_addr   = head_ff;
      status_in = ST_OK;
      if (cmd.push) begin
         if (stat.full) begin
            status_in = ST_FULL;
         end else if (stat.empty) begin
            // first item always lands in slot zero
            head_in  = '0;
            tail_in  = '0;
            wr_addr  = '0;
            count_in = ONE_CNT;
         end else if (cmd.at_front) begin
            head_in  = step_down(head_ff);
            wr_addr  = head_in;
            count_in = count_ff + ONE_CNT;
         end else begin
            tail_in  = step_up(tail_ff);
            wr_addr  = tail_in;
            count_in = count_ff + ONE_CNT;
         end
      end else begin
         if (stat.empty) begin
            status_in = ST_EMPTY;
         end else begin
            rd_addr  = cmd.at_front ? head_ff : tail_ff;
            count_in = count_ff - ONE_CNT;
            if (count_ff == ONE_CNT) begin
               head_in = '0;
               tail_in = '0;
            end else if (cmd.at_front) begin
               head_in = step_up(head_ff);
            end else begin
               tail_in = step_down(tail_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         status_ff  <= ST_OK;
         pop_sel_ff <= 1'b0;
      end else if (cmd.take) begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         count_ff   <= count_in;
         status_ff  <= status_in;
         pop_sel_ff <= rd_en;
      end
   end

   // ring memory, one write or one registered read per transfer
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_mem[wr_addr] <= push_value;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign pop_value  = pop_sel_ff ? rd_data_ff : '0;
   assign status     = status_ff;
   assign item_count = count_ff;
   assign front_slot = stat.empty ? '1 : {1'b0, head_ff};
   assign rear_slot  = stat.empty ? '1 : {1'b0, tail_ff};

endmodule

FILE: rtl/ring_buffer_deque_unit.sv
// top level of the ring buffer deque: controller plus datapath
//
// channel | dir | handshake          | tdata fields, lowest bit first
// req     | in  | req_tvalid/tready  | cmd[1:0], push_value[33:2], zero pad to 40
// rsp     | out | rsp_tvalid/tready  | pop_value, status, item_count, front_slot,
//         |     |                    | rear_slot, zero pad to whole bytes
//
// pushes and failed pops go straight to the waiting result: a new transfer is taken in the same
// cycle that the waiting result leaves
// a successful pop passes through S_READ first, for the registered read of the ring memory
// reset clears pointers, occupancy, status and controller state; the ring memory needs no clearing pass
// a stalled result holds its fields and blocks new requests until it is taken
module ring_buffer_deque_unit #(
   parameter int RING_DEPTH = rbd_pkg::RBD_DEPTH,
   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
   localparam int CNT_W = $clog2(RING_DEPTH + 1),
   localparam int RSP_BITS = rbd_pkg::VALUE_W + rbd_pkg::STATUS_W + CNT_W + 2 * (PTR_W + 1),
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // cmd, push_value
   input  logic [rbd_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pop_value, status, item_count, front_slot, rear_slot
   output logic [RSP_TDATA_W-1:0]           rsp_tdata
);
   import rbd_pkg::*;

   rbd_cmd_type         cmd;
   rbd_stat_type        stat;
   logic [CMD_W-1:0]    req_cmd;
   logic [VALUE_W-1:0]  req_push_value;
   logic [VALUE_W-1:0]  pop_value;
   logic [STATUS_W-1:0] status;
   logic [CNT_W-1:0]    item_count;
   logic [PTR_W:0]      front_slot;
   logic [PTR_W:0]      rear_slot;

   // unpack the request transfer
   assign req_cmd        = req_tdata[CMD_W-1:0];
   assign req_push_value = req_tdata[CMD_W +: VALUE_W];

   rbd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rbd_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_value (req_push_value),
      .stat       (stat),
      .pop_value  (pop_value),
      .status     (status),
      .item_count (item_count),
      .front_slot (front_slot),
      .rear_slot  (rear_slot)
   );

   // pack the result transfer, pad bits held at zero
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_BITS-1:0] = {rear_slot, front_slot, item_count, status, pop_value};
   end

endmodule

FILE: rtl/rbd_checker.sv
// port-level checks of the ring buffer deque, bound to the top level
module rbd_checker #(
   parameter int RING_DEPTH = rbd_pkg::RBD_DEPTH,
   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
   localparam int CNT_W = $clog2(RING_DEPTH + 1),
   localparam int RSP_BITS = rbd_pkg::VALUE_W + rbd_pkg::STATUS_W + CNT_W + 2 * (PTR_W + 1),
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   // cmd, push_value
   input logic [rbd_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   // pop_value, status, item_count, front_slot, rear_slot
   input logic [RSP_TDATA_W-1:0]          rsp_tdata
);
   import rbd_pkg::*;

   localparam int ST_LO    = VALUE_W;
   localparam int CNT_LO   = ST_LO + STATUS_W;
   localparam int FRONT_LO = CNT_LO + CNT_W;
   localparam int REAR_LO  = FRONT_LO + PTR_W + 1;

   logic [VALUE_W-1:0]  f_pop;
   logic [STATUS_W-1:0] f_status;
   logic [CNT_W-1:0]    f_count;
   logic [PTR_W:0]      f_front;
   logic [PTR_W:0]      f_rear;

   assign f_pop    = rsp_tdata[VALUE_W-1:0];
   assign f_status = rsp_tdata[ST_LO +: STATUS_W];
   assign f_count  = rsp_tdata[CNT_LO +: CNT_W];
   assign f_front  = rsp_tdata[FRONT_LO +: PTR_W + 1];
   assign f_rear   = rsp_tdata[REAR_LO +: PTR_W + 1];

   // a held result keeps its fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // an empty deque reports both slots as minus one
   a_empty_slots: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (f_count == '0) |-> (f_front == '1) && (f_rear == '1))
      else $error("empty deque with a valid slot");

   // only a successful pop carries a value
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (f_status != ST_OK) |-> (f_pop == '0))
      else $error("failed command returned data");

   // a refused push only happens at full capacity
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (f_status == ST_FULL) |-> (f_count == CNT_W'(RING_DEPTH)))
      else $error("push refused below capacity");

   // no result without an earlier request transfer
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready) || $past(rsp_tvalid, 2) ||
         $past(req_tvalid && req_tready, 2))
      else $error("result without request");

endmodule

bind ring_buffer_deque_unit rbd_checker #(.RING_DEPTH(RING_DEPTH)) u_rbd_checker (.*);
